// ----- design/keyed_lru_directory_top_defines.svh -----
// ----------------------------------------------------------------------------
// keyed_lru_directory_top_defines
// assertion macros shared by the keyed lru directory modules
// ----------------------------------------------------------------------------
`ifndef KEYED_LRU_DIRECTORY_TOP_DEFINES_SVH
`define KEYED_LRU_DIRECTORY_TOP_DEFINES_SVH

`ifndef SYNTH
// property checked while out of reset
`define KLD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// property checked on every edge, reset included
`define KLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KLD_ASSERT(lbl, clk, rstn, prop, msg)
`define KLD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- design/kld_pkg.sv -----
// ----------------------------------------------------------------------------
// kld_pkg
// shared constants and control types of the keyed lru directory
// ----------------------------------------------------------------------------
`default_nettype none

package kld_pkg;

    localparam int CACHE_SIZE_DEF = 16;

    localparam int FUNC_W  = 3;
    localparam int ID_W    = 64;
    localparam int TIME_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    // stamp value that can never be chosen as a victim
    localparam logic [TIME_W-1:0] NO_STAMP = 32'hFFFF_FFFF;

    // sequencer to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } t_ctrl_cmd;

    // datapath to sequencer
    typedef struct packed {
        logic scan_op;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/kld_ctrl.sv -----
// ----------------------------------------------------------------------------
// kld_ctrl
// sequencer: accepts a command, sweeps the entry memory for add, find, remove and touch, then commits
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_lru_directory_top_defines.svh"

module kld_ctrl
    import kld_pkg::*;
#(
    parameter int CACHE_SIZE = CACHE_SIZE_DEF,
    parameter int IW         = $clog2(CACHE_SIZE)
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_dp_stat    i_stat,
    output t_ctrl_cmd        o_cmd,
    output logic [IW-1:0]    o_rd_addr,
    output logic             o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_COMMIT
    } t_state;

    t_state        r_state;
    logic [IW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) begin
                        r_state <= i_stat.scan_op ? S_SCAN : S_COMMIT;
                    end
                end
                S_SCAN: begin
                    if (r_cnt == IW'(CACHE_SIZE - 1)) begin
                        r_state <= S_LAST;
                    end else begin
                        r_cnt <= r_cnt + IW'(1);
                    end
                end
                // compare of the final entry
                S_LAST:   r_state <= S_COMMIT;
                S_COMMIT: r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.rd_en  = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_COMMIT);
    end

    assign o_rd_addr = r_cnt;
    assign o_busy    = (r_state != S_IDLE);

    `KLD_ASSERT(a_accept_busy, i_clk, i_rst_n, (i_start && !o_busy) |=> o_busy, "accept not followed by busy")
    `KLD_ASSERT(a_last_commit, i_clk, i_rst_n, (r_state == S_LAST) |=> o_cmd.commit, "final compare not followed by commit")
    `KLD_ASSERT(a_commit_free, i_clk, i_rst_n, o_cmd.commit |=> !o_busy, "busy held after commit")

endmodule

`default_nettype wire

// ----- design/kld_dp.sv -----
// ----------------------------------------------------------------------------
// kld_dp
// entry storage, sweep compare, victim choice and result registers
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_lru_directory_top_defines.svh"

module kld_dp
    import kld_pkg::*;
#(
    parameter int CACHE_SIZE = CACHE_SIZE_DEF,
    parameter int IW         = $clog2(CACHE_SIZE),
    parameter int CW         = $clog2(CACHE_SIZE + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [FUNC_W-1:0]  i_func,
    input  wire logic [ID_W-1:0]    i_peer_id,
    input  wire logic [TIME_W-1:0]  i_now,
    input  wire t_ctrl_cmd          i_cmd,
    input  wire logic [IW-1:0]      i_rd_addr,
    output t_dp_stat                o_stat,
    output logic                    o_done,
    output logic                    o_ok,
    output logic                    o_hit,
    output logic [SLOT_W-1:0]       o_slot,
    output logic                    o_evicted,
    output logic [TIME_W-1:0]       o_last_seen,
    output logic [COUNT_W-1:0]      o_entry_count
);

    // entry memories, one write and one read port each
    logic [ID_W-1:0]   mem_key   [CACHE_SIZE];
    logic [TIME_W-1:0] mem_seen  [CACHE_SIZE];
    logic [TIME_W-1:0] mem_stamp [CACHE_SIZE];

    logic [CACHE_SIZE-1:0] r_valid;
    logic [TIME_W-1:0]     r_clock;
    logic [CW-1:0]         r_count;

    logic [FUNC_W-1:0] r_func;
    logic [ID_W-1:0]   r_key;
    logic [TIME_W-1:0] r_now;

    logic [ID_W-1:0]   r_rd_key;
    logic [TIME_W-1:0] r_rd_seen;
    logic [TIME_W-1:0] r_rd_stamp;
    logic              r_cmp_en;
    logic [IW-1:0]     r_cmp_idx;

    logic              r_match_hit;
    logic [IW-1:0]     r_match_idx;
    logic [TIME_W-1:0] r_match_seen;
    logic              r_free_hit;
    logic [IW-1:0]     r_free_idx;
    logic              r_lru_hit;
    logic [IW-1:0]     r_lru_idx;
    logic [TIME_W-1:0] r_lru_low;

    logic r_done;

    logic                  cmp_valid;
    logic                  wr_key_en;
    logic                  wr_seen_en;
    logic                  wr_stamp_en;
    logic [IW-1:0]         wr_idx;
    logic [TIME_W-1:0]     wr_seen;
    logic [TIME_W-1:0]     stamp_next;
    logic                  set_valid;
    logic                  clr_valid;
    logic                  clr_all;
    logic                  bump;
    logic                  res_ok;
    logic                  res_hit;
    logic                  res_evict;
    logic [TIME_W-1:0]     res_seen;
    logic [IW-1:0]         res_idx;
    logic [CW-1:0]         n_count;
    logic [IW+SLOT_W-1:0]  slot_ext;
    logic [CW+COUNT_W-1:0] count_ext;

    always_comb begin
        o_stat.scan_op = (i_func inside {FUNC_ADD, FUNC_FIND, FUNC_REMOVE, FUNC_TOUCH});
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_key_en) begin
            mem_key[wr_idx] <= r_key;
        end
        r_rd_key <= mem_key[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_seen_en) begin
            mem_seen[wr_idx] <= wr_seen;
        end
        r_rd_seen <= mem_seen[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_stamp_en) begin
            mem_stamp[wr_idx] <= stamp_next;
        end
        r_rd_stamp <= mem_stamp[i_rd_addr];
    end

    assign cmp_valid = r_valid[r_cmp_idx];

    // sweep compare, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_en <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.rd_en;
        end
        r_cmp_idx <= i_rd_addr;
        if (i_cmd.load) begin
            r_func       <= i_func;
            r_key        <= i_peer_id;
            r_now        <= i_now;
            r_match_hit  <= 1'b0;
            r_match_idx  <= '0;
            r_match_seen <= '0;
            r_free_hit   <= 1'b0;
            r_free_idx   <= '0;
            r_lru_hit    <= 1'b0;
            r_lru_idx    <= '0;
            r_lru_low    <= NO_STAMP;
        end else if (r_cmp_en) begin
            if (!r_match_hit && cmp_valid && (r_rd_key == r_key)) begin
                r_match_hit  <= 1'b1;
                r_match_idx  <= r_cmp_idx;
                r_match_seen <= r_rd_seen;
            end
            if (!r_free_hit && !cmp_valid) begin
                r_free_hit <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
            // strict compare keeps the lowest index on a tie
            if (cmp_valid && (r_rd_stamp < r_lru_low)) begin
                r_lru_hit <= 1'b1;
                r_lru_idx <= r_cmp_idx;
                r_lru_low <= r_rd_stamp;
            end
        end
    end

    // commit decision
    always_comb begin
        wr_key_en   = 1'b0;
        wr_seen_en  = 1'b0;
        wr_stamp_en = 1'b0;
        wr_idx      = r_match_idx;
        wr_seen     = r_now;
        stamp_next  = r_clock + TIME_W'(1);
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        clr_all     = 1'b0;
        bump        = 1'b0;
        res_ok      = 1'b0;
        res_hit     = 1'b0;
        res_evict   = 1'b0;
        res_seen    = '0;
        res_idx     = '0;
        n_count     = r_count;
        case (r_func)
            FUNC_ADD: begin
                if (r_match_hit) begin
                    res_hit = 1'b1;
                end else if (r_free_hit) begin
                    wr_idx  = r_free_idx;
                    n_count = r_count + CW'(1);
                end else if (r_lru_hit) begin
                    wr_idx    = r_lru_idx;
                    res_evict = 1'b1;
                end
                if (r_match_hit || r_free_hit || r_lru_hit) begin
                    wr_key_en   = 1'b1;
                    wr_seen_en  = 1'b1;
                    wr_stamp_en = 1'b1;
                    set_valid   = 1'b1;
                    bump        = 1'b1;
                    res_ok      = 1'b1;
                    res_seen    = r_now;
                    res_idx     = wr_idx;
                end
            end
            FUNC_FIND: begin
                if (r_match_hit) begin
                    wr_stamp_en = 1'b1;
                    bump        = 1'b1;
                    res_ok      = 1'b1;
                    res_hit     = 1'b1;
                    res_seen    = r_match_seen;
                    res_idx     = r_match_idx;
                end
            end
            FUNC_REMOVE: begin
                if (r_match_hit) begin
                    clr_valid = 1'b1;
                    n_count   = r_count - CW'(1);
                    res_ok    = 1'b1;
                    res_hit   = 1'b1;
                    res_idx   = r_match_idx;
                end
            end
            FUNC_TOUCH: begin
                if (r_match_hit) begin
                    wr_seen_en  = 1'b1;
                    wr_stamp_en = 1'b1;
                    bump        = 1'b1;
                    res_ok      = 1'b1;
                    res_hit     = 1'b1;
                    res_seen    = r_now;
                    res_idx     = r_match_idx;
                end
            end
            FUNC_CLEAR: begin
                clr_all = 1'b1;
                n_count = '0;
                res_ok  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign slot_ext  = {{SLOT_W{1'b0}}, res_idx};
    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    // directory state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_clock <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.commit) begin
                r_count <= n_count;
                if (clr_all) begin
                    r_valid <= '0;
                    r_clock <= '0;
                end else begin
                    if (set_valid) begin
                        r_valid[wr_idx] <= 1'b1;
                    end
                    if (clr_valid) begin
                        r_valid[wr_idx] <= 1'b0;
                    end
                    if (bump) begin
                        r_clock <= stamp_next;
                    end
                end
            end
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_ok          <= res_ok;
            o_hit         <= res_hit;
            o_slot        <= slot_ext[SLOT_W-1:0];
            o_evicted     <= res_evict;
            o_last_seen   <= res_seen;
            o_entry_count <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_done = r_done;

    `KLD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CACHE_SIZE), "entry count above size")
    `KLD_ASSERT(a_done_after_commit, i_clk, i_rst_n, i_cmd.commit |=> o_done, "commit without result beat")
    `KLD_ASSERT(a_fail_zero, i_clk, i_rst_n, (o_done && !o_ok) |-> (o_slot == '0 && o_last_seen == '0 && !o_hit), "failed beat carries data")
    `KLD_ASSERT(a_done_single, i_clk, i_rst_n, o_done |=> !o_done, "result beat longer than one cycle")

endmodule

`default_nettype wire

// ----- design/keyed_lru_directory_top.sv -----
// ----------------------------------------------------------------------------
// keyed_lru_directory_top
// fully associative peer directory keyed by a 64-bit id, lru replacement
// ----------------------------------------------------------------------------
//  channel   | handshake          | ports
//  ----------+--------------------+---------------------------------------------
//  command   | start & !busy      | i_func, i_peer_id, i_now
//  result    | o_done (1 cycle)   | o_ok, o_hit, o_slot, o_evicted, o_last_seen,
//            |                    | o_entry_count
//
//  add, find, remove and touch sweep every entry while busy is high, and
//  the result beat follows; the sweep length is set by the single read
//  port of each entry memory, which reads one entry at a time
//  clear and unused codes skip the sweep and go straight to commit
//  a new command may be accepted in the cycle that shows the result beat
//  reset clears the valid flags, stamp counter and count at once; no sweep
//  the receiver cannot stall; each result beat lasts exactly one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_lru_directory_top
    import kld_pkg::*;
#(
    parameter int CACHE_SIZE = CACHE_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [FUNC_W-1:0]  i_func,
    input  wire logic [ID_W-1:0]    i_peer_id,
    input  wire logic [TIME_W-1:0]  i_now,
    output logic                    o_done,
    output logic                    o_ok,
    output logic                    o_hit,
    output logic [SLOT_W-1:0]       o_slot,
    output logic                    o_evicted,
    output logic [TIME_W-1:0]       o_last_seen,
    output logic [COUNT_W-1:0]      o_entry_count
);

    localparam int IW = $clog2(CACHE_SIZE);

    // sequencer commands and datapath status
    t_ctrl_cmd     cmd;
    t_dp_stat      stat;
    logic [IW-1:0] rd_addr;

    kld_ctrl #(
        .CACHE_SIZE (CACHE_SIZE)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr),
        .o_busy    (busy)
    );

    // entry memories, sweep compare and result beat
    kld_dp #(
        .CACHE_SIZE (CACHE_SIZE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_func        (i_func),
        .i_peer_id     (i_peer_id),
        .i_now         (i_now),
        .i_cmd         (cmd),
        .i_rd_addr     (rd_addr),
        .o_stat        (stat),
        .o_done        (o_done),
        .o_ok          (o_ok),
        .o_hit         (o_hit),
        .o_slot        (o_slot),
        .o_evicted     (o_evicted),
        .o_last_seen   (o_last_seen),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire
